[hdl/bsg_pkg.sv]
package bsg_pkg;

    // Field widths.
    localparam int CoordBits = 30;
    localparam int RadBits   = CoordBits + 1;
    localparam int DiffBits  = CoordBits + 1;
    localparam int MulBits   = 32;
    localparam int ProdBits  = 2 * MulBits;
    localparam int LenBits   = 32;
    localparam int SqrtSteps = LenBits;
    localparam int DivSteps  = RadBits;
    localparam int CntBits   = 5;

    // Operation codes of an input request.
    localparam logic OpAdd  = 1'b0;
    localparam logic OpLoad = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQMUL,
        S_SQRT,
        S_AXMUL,
        S_DIV,
        S_DONE
    } t_state;

    // Modes of the shift-subtract unit.
    typedef enum logic {
        IT_SQRT,
        IT_DIV
    } t_it_mode;

    typedef struct packed {
        logic     start;
        t_it_mode mode;
    } t_it_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_it_stat;

    // Magnitude of a signed difference.
    function automatic logic [DiffBits-1:0] mag_f(input logic signed [DiffBits-1:0] v);
        logic [DiffBits-1:0] m;
        m = v[DiffBits-1] ? DiffBits'(-v) : DiffBits'(v);
        return m;
    endfunction

    // Saturate a wide signed sum to the coordinate range.
    function automatic logic signed [CoordBits-1:0] sat_f(
        input logic signed [CoordBits+2:0] v
    );
        logic signed [CoordBits+2:0] hi;
        logic signed [CoordBits+2:0] lo;
        logic signed [CoordBits-1:0] r;
        hi = (CoordBits+3)'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
        lo = -hi - (CoordBits+3)'(1);
        if (v > hi) begin
            r = hi[CoordBits-1:0];
        end else if (v < lo) begin
            r = lo[CoordBits-1:0];
        end else begin
            r = v[CoordBits-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/bsg_mul.sv]
module bsg_mul (
    input  logic                           i_clk,
    input  logic [bsg_pkg::MulBits-1:0]    i_a,
    input  logic [bsg_pkg::MulBits-1:0]    i_b,
    output logic [bsg_pkg::ProdBits-1:0]   o_prod
);

    logic [bsg_pkg::ProdBits-1:0] r_prod;

    // Registered unsigned product.
    always_ff @(posedge i_clk) begin
        r_prod <= bsg_pkg::ProdBits'(i_a) * bsg_pkg::ProdBits'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[hdl/bsg_iter.sv]
module bsg_iter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsg_pkg::t_it_cmd              i_cmd,
    input  logic [bsg_pkg::ProdBits-1:0]  i_a,
    input  logic [bsg_pkg::LenBits-1:0]   i_b,
    output bsg_pkg::t_it_stat             o_stat,
    output logic [bsg_pkg::LenBits-1:0]   o_result
);

    localparam int W = bsg_pkg::ProdBits;
    localparam int L = bsg_pkg::LenBits;
    localparam int Q = bsg_pkg::DivSteps;

    logic                          r_run;
    logic                          r_done;
    logic [bsg_pkg::CntBits-1:0]   r_cnt;
    bsg_pkg::t_it_mode             r_mode;
    logic [W-1:0]                  r_v;
    logic [W-1:0]                  r_res;
    logic [L-1:0]                  r_dvs;

    logic [W-1:0]  bitv;
    logic [L:0]    trial;
    logic [W-1:0]  cmp_a;
    logic [W-1:0]  cmp_b;
    logic [W:0]    diff;
    logic          ge;

    // One shared subtractor serves both the root and the divide step.
    always_comb begin
        bitv  = W'(1) << {r_cnt, 1'b0};
        trial = {r_res[L-1:0], r_v[Q-1]};
        if (r_mode == bsg_pkg::IT_SQRT) begin
            cmp_a = r_v;
            cmp_b = r_res + bitv;
        end else begin
            cmp_a = W'(trial);
            cmp_b = W'(r_dvs);
        end
        diff = {1'b0, cmp_a} - {1'b0, cmp_b};
        ge   = !diff[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= bsg_pkg::IT_SQRT;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_cmd.start) begin
                r_run  <= 1'b1;
                r_mode <= i_cmd.mode;
                r_cnt  <= (i_cmd.mode == bsg_pkg::IT_SQRT) ?
                          bsg_pkg::CntBits'(bsg_pkg::SqrtSteps - 1) :
                          bsg_pkg::CntBits'(Q - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvs <= i_b;
            if (i_cmd.mode == bsg_pkg::IT_SQRT) begin
                r_v   <= i_a;
                r_res <= '0;
            end else begin
                // The quotient fits Q bits, so the high part is below the divisor.
                r_res <= W'(i_a[Q+L-1:Q]);
                r_v   <= W'(i_a[Q-1:0]);
            end
        end else if (r_run) begin
            if (r_mode == bsg_pkg::IT_SQRT) begin
                if (ge) begin
                    r_v   <= diff[W-1:0];
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
            end else begin
                r_res <= ge ? diff[W-1:0] : W'(trial);
                r_v   <= {r_v[W-2:0], ge};
            end
        end
    end

    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;
    assign o_result    = (r_mode == bsg_pkg::IT_SQRT) ? r_res[L-1:0] : L'(r_v[Q-1:0]);

endmodule

[hdl/bounding_sphere_point_grow_core.sv]
// Bounding sphere grown one point at a time.
// Input channel: i_valid / o_ready carry a request with i_operation, a point
// (i_point_x/y/z, signed Q14.16) and i_load_radius. A load request sets the
// sphere; an add request grows it to enclose the point when the point lies
// outside. Output channel: o_valid / i_ready carry the sphere after the request
// and o_grew.
// A load request goes straight to the output stage. An add request first forms
// the squared distance and the squared radius and stops there for a point
// inside the sphere; a point that grows the sphere then uses the shared
// shift-subtract unit: a 32-step square root, then one 31-step division per
// axis, each after a product from the single 32x32 multiplier. One request is
// worked on at a time; o_ready is high only while the sequencer is idle, which
// it is again from the cycle in which the result enters the output register.
// A finished result waits there while the receiver stalls, and the next request
// may be accepted meanwhile. Reset (synchronous, active low) clears the sphere
// to center zero and radius zero and empties the output register.
module bounding_sphere_point_grow_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_operation,
    input  logic signed [bsg_pkg::CoordBits-1:0]   i_point_x,
    input  logic signed [bsg_pkg::CoordBits-1:0]   i_point_y,
    input  logic signed [bsg_pkg::CoordBits-1:0]   i_point_z,
    input  logic [bsg_pkg::RadBits-1:0]            i_load_radius,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [bsg_pkg::CoordBits-1:0]   o_center_x,
    output logic signed [bsg_pkg::CoordBits-1:0]   o_center_y,
    output logic signed [bsg_pkg::CoordBits-1:0]   o_center_z,
    output logic [bsg_pkg::RadBits-1:0]            o_sphere_radius,
    output logic                                   o_grew
);

    localparam int C = bsg_pkg::CoordBits;
    localparam int R = bsg_pkg::RadBits;
    localparam int D = bsg_pkg::DiffBits;
    localparam int M = bsg_pkg::MulBits;
    localparam int P = bsg_pkg::ProdBits;
    localparam int L = bsg_pkg::LenBits;

    bsg_pkg::t_state r_state, n_state;

    logic signed [C-1:0] r_c [3];
    logic signed [C-1:0] n_c [3];
    logic signed [C-1:0] r_p [3];
    logic signed [D-1:0] r_d [3];
    logic [R-1:0]        r_rad, n_rad;
    logic [R-1:0]        r_dist, n_dist;
    logic [L-1:0]        r_len, n_len;
    logic [P-1:0]        r_len2, n_len2;
    logic [2:0]          r_k, n_k;
    logic [1:0]          r_axis, n_axis;
    logic                r_grew, n_grew;
    logic                r_ovalid;
    logic signed [C-1:0] r_oc [3];
    logic [R-1:0]        r_orad;
    logic                r_ogrew;

    logic                accept;
    logic                out_load;
    logic [1:0]          sel;
    logic signed [D-1:0] dsel;
    logic [D-1:0]        msel;
    logic [M-1:0]        mul_a, mul_b;
    logic [P-1:0]        prod;
    bsg_pkg::t_it_cmd    it_cmd;
    bsg_pkg::t_it_stat   it_stat;
    logic [L-1:0]        it_res;
    logic [P-1:0]        it_a;
    logic [L:0]          sum_len;
    logic signed [C+2:0] moved;
    logic signed [C+2:0] step;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == bsg_pkg::S_IDLE);
    assign sel    = (r_state == bsg_pkg::S_SQMUL) ? r_k[1:0] : r_axis;
    assign dsel   = r_d[sel];
    assign msel   = bsg_pkg::mag_f(dsel);

    bsg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    bsg_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (it_cmd),
        .i_a      (it_a),
        .i_b      (r_len),
        .o_stat   (it_stat),
        .o_result (it_res)
    );

    // Sequencer: next state, operand selection and sphere updates.
    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_rad   = r_rad;
        n_dist  = r_dist;
        n_len   = r_len;
        n_len2  = r_len2;
        n_k     = r_k;
        n_axis  = r_axis;
        n_grew  = r_grew;
        out_load = 1'b0;
        mul_a   = M'(msel);
        mul_b   = M'(msel);
        it_cmd.start = 1'b0;
        it_cmd.mode  = bsg_pkg::IT_SQRT;
        it_a    = r_len2;
        sum_len = (L+1)'(it_res) + (L+1)'(r_rad);
        step    = (C+3)'($signed({1'b0, it_res[R-1:0]}));
        if (dsel[D-1]) begin
            step = -step;
        end
        moved   = (C+3)'(r_p[r_axis]) + step;
        unique case (r_state)
            bsg_pkg::S_IDLE: begin
                if (accept) begin
                    n_grew = 1'b0;
                    n_k    = '0;
                    if (i_operation == bsg_pkg::OpLoad) begin
                        n_c[0]  = i_point_x;
                        n_c[1]  = i_point_y;
                        n_c[2]  = i_point_z;
                        n_rad   = i_load_radius;
                        n_state = bsg_pkg::S_DONE;
                    end else begin
                        n_state = bsg_pkg::S_SQMUL;
                    end
                end
            end
            bsg_pkg::S_SQMUL: begin
                // Squares of the three axes, then the radius, one per cycle.
                if (r_k == 3'd3) begin
                    mul_a = M'(r_rad);
                    mul_b = M'(r_rad);
                end
                if (r_k == 3'd1) begin
                    n_len2 = prod;
                end else if (r_k == 3'd2 || r_k == 3'd3) begin
                    n_len2 = r_len2 + prod;
                end
                n_k = r_k + 1'b1;
                if (r_k == 3'd4) begin
                    if (r_len2 > prod) begin
                        it_cmd.start = 1'b1;
                        n_state = bsg_pkg::S_SQRT;
                    end else begin
                        n_state = bsg_pkg::S_DONE;
                    end
                end
            end
            bsg_pkg::S_SQRT: begin
                if (it_stat.done) begin
                    n_len   = it_res;
                    n_dist  = sum_len[L] ? '1 : sum_len[R:1];
                    n_axis  = '0;
                    n_k     = '0;
                    n_state = bsg_pkg::S_AXMUL;
                end
            end
            bsg_pkg::S_AXMUL: begin
                // Scale the axis offset by the new radius, then divide by length.
                mul_b = M'(r_dist);
                n_k   = r_k + 1'b1;
                if (r_k != '0) begin
                    it_cmd.start = 1'b1;
                    it_cmd.mode  = bsg_pkg::IT_DIV;
                    it_a    = prod;
                    n_state = bsg_pkg::S_DIV;
                end
            end
            bsg_pkg::S_DIV: begin
                if (it_stat.done) begin
                    n_c[r_axis] = bsg_pkg::sat_f(moved);
                    n_k = '0;
                    if (r_axis == 2'd2) begin
                        n_rad   = r_dist;
                        n_grew  = 1'b1;
                        n_state = bsg_pkg::S_DONE;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = bsg_pkg::S_AXMUL;
                    end
                end
            end
            bsg_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = bsg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsg_pkg::S_IDLE;
            end
        endcase
    end

    // Control and sphere state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bsg_pkg::S_IDLE;
            r_c[0]   <= '0;
            r_c[1]   <= '0;
            r_c[2]   <= '0;
            r_rad    <= '0;
            r_k      <= '0;
            r_axis   <= '0;
            r_grew   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_rad   <= n_rad;
            r_k     <= n_k;
            r_axis  <= n_axis;
            r_grew  <= n_grew;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers of the request and the output register.
    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_len  <= n_len;
        r_len2 <= n_len2;
        if (accept) begin
            r_p[0] <= i_point_x;
            r_p[1] <= i_point_y;
            r_p[2] <= i_point_z;
            r_d[0] <= D'(r_c[0]) - D'(i_point_x);
            r_d[1] <= D'(r_c[1]) - D'(i_point_y);
            r_d[2] <= D'(r_c[2]) - D'(i_point_z);
        end
        if (out_load) begin
            r_oc    <= r_c;
            r_orad  <= r_rad;
            r_ogrew <= r_grew;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_center_x      = r_oc[0];
    assign o_center_y      = r_oc[1];
    assign o_center_z      = r_oc[2];
    assign o_sphere_radius = r_orad;
    assign o_grew          = r_ogrew;

`ifndef ASSERT_OFF
    // The shared unit runs only while the sequencer waits on it.
    a_iter_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (it_stat.busy || it_stat.done) |->
        (r_state == bsg_pkg::S_SQRT || r_state == bsg_pkg::S_DIV))
        else $error("shift-subtract unit active outside its states");

    // A grown sphere never has a smaller radius.
    a_grow_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsg_pkg::S_DIV && it_stat.done && r_axis == 2'd2) |->
        (r_dist >= r_rad))
        else $error("grown radius below old radius");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != bsg_pkg::S_IDLE))
        else $error("request accepted without starting work");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int CW = bsg_pkg::CoordBits;
    localparam int RW = bsg_pkg::RadBits;
    localparam longint CMAX_V = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN_V = -CMAX_V - 1;
    localparam longint RMAX_V = (64'sd1 <<< RW) - 1;
    localparam int LIMIT = 2_000_000;

    typedef struct packed {
        logic                 op;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic [RW-1:0]        rad;
    } t_req;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic [RW-1:0]        r;
        logic                 grew;
    } t_sphere;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_operation = 1'b0;
    logic signed [CW-1:0] i_point_x = '0;
    logic signed [CW-1:0] i_point_y = '0;
    logic signed [CW-1:0] i_point_z = '0;
    logic [RW-1:0]        i_load_radius = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [CW-1:0] o_center_x;
    logic signed [CW-1:0] o_center_y;
    logic signed [CW-1:0] o_center_z;
    logic [RW-1:0]        o_sphere_radius;
    logic                 o_grew;

    bounding_sphere_point_grow_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Sphere tracked by the predictor.
    longint  cen_x, cen_y, cen_z;
    longint  rad_q;

    t_req    req_q[$];
    t_sphere sphere_q[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_send = 1'b0;
    longint  cycles = 0;

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > CMAX_V) return CMAX_V;
        if (v < CMIN_V) return CMIN_V;
        return v;
    endfunction

    // Point plus the difference scaled by new_rad/len, truncated toward zero.
    function automatic longint shift_axis(longint p, longint d, longint new_rad, longint len);
        longint unsigned q;
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : d;
        q = (m * longint'(new_rad)) / longint'(len);
        return clamp_coord(d < 0 ? p - longint'(q) : p + longint'(q));
    endfunction

    function automatic t_sphere grow_sphere(t_req q);
        t_sphere s;
        longint px, py, pz, dx, dy, dz, len, new_rad;
        longint unsigned len2, r2;
        px = q.px;
        py = q.py;
        pz = q.pz;
        s.grew = 1'b0;
        if (q.op == bsg_pkg::OpLoad) begin
            cen_x = px;
            cen_y = py;
            cen_z = pz;
            rad_q = q.rad;
        end else begin
            dx = cen_x - px;
            dy = cen_y - py;
            dz = cen_z - pz;
            len2 = dx * dx + dy * dy + dz * dz;
            r2 = rad_q * rad_q;
            if (len2 > r2) begin
                len = floor_sqrt(len2);
                new_rad = (len + rad_q) >> 1;
                if (new_rad > RMAX_V) new_rad = RMAX_V;
                cen_x = shift_axis(px, dx, new_rad, len);
                cen_y = shift_axis(py, dy, new_rad, len);
                cen_z = shift_axis(pz, dz, new_rad, len);
                rad_q = new_rad;
                s.grew = 1'b1;
            end
        end
        s.cx = cen_x[CW-1:0];
        s.cy = cen_y[CW-1:0];
        s.cz = cen_z[CW-1:0];
        s.r = rad_q[RW-1:0];
        return s;
    endfunction

    function automatic t_req make_req(logic op, longint x, longint y, longint z, longint r);
        t_req q;
        q.op = op;
        q.px = x[CW-1:0];
        q.py = y[CW-1:0];
        q.pz = z[CW-1:0];
        q.rad = r[RW-1:0];
        return q;
    endfunction

    function automatic longint rand_coord(int mode);
        case (mode)
            0: return longint'($urandom_range(0, 2000)) - 1000;
            1: return longint'($urandom_range(0, 20_000_000)) - 10_000_000;
            default: return longint'($signed($urandom_range(0, (1 << CW) - 1) << 2)) >>> 2;
        endcase
    endfunction

    // Driver: present the next request, keep it until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sphere_q.push_back(grow_sphere(req_q.pop_front()));
            end
            if (!(i_valid && !o_ready)) begin
                if (req_q.size() > 0 && !hold_send
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_req n;
                    n = req_q[0];
                    i_valid <= 1'b1;
                    i_operation <= n.op;
                    i_point_x <= n.px;
                    i_point_y <= n.py;
                    i_point_z <= n.pz;
                    i_load_radius <= n.rad;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (o_valid && i_ready) begin
                if (sphere_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d r=%0d g=%0b", $time,
                             o_center_x, o_center_y, o_center_z, o_sphere_radius, o_grew);
                    errors++;
                end else begin
                    t_sphere e;
                    e = sphere_q.pop_front();
                    if (o_center_x !== e.cx || o_center_y !== e.cy || o_center_z !== e.cz
                            || o_sphere_radius !== e.r || o_grew !== e.grew) begin
                        $display("%0t: expected x=%0d y=%0d z=%0d r=%0d g=%0b", $time,
                                 e.cx, e.cy, e.cz, e.r, e.grew);
                        $display("%0t: actual   x=%0d y=%0d z=%0d r=%0d g=%0b", $time,
                                 o_center_x, o_center_y, o_center_z, o_sphere_radius, o_grew);
                        errors++;
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("** bounding_sphere_point_grow_core: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (req_q.size() != 0 || i_valid || sphere_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        int k, mode;
        for (k = 0; k < n; k++) begin
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                req_q.push_back(make_req(bsg_pkg::OpLoad, rand_coord(mode), rand_coord(mode),
                                         rand_coord(mode),
                                         $urandom_range(0, 7) == 0 ?
                                         longint'($urandom_range(0, 32'h7fff_ffff)) :
                                         longint'($urandom_range(0, 20_000_000))));
            end else begin
                req_q.push_back(make_req(bsg_pkg::OpAdd, rand_coord(mode), rand_coord(mode),
                                         rand_coord(mode), longint'($urandom())));
            end
        end
    endtask

    initial begin
        cen_x = 0;
        cen_y = 0;
        cen_z = 0;
        rad_q = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero-radius start, point at the center, inside, on, far corners.
        req_q.push_back(make_req(bsg_pkg::OpAdd, 0, 0, 0, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, 65536, 0, 0, RMAX_V));
        req_q.push_back(make_req(bsg_pkg::OpAdd, 32768, 0, 0, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, 65536, 0, 0, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, CMAX_V, CMAX_V, CMAX_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, CMIN_V, CMIN_V, CMIN_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpLoad, CMAX_V, CMIN_V, CMAX_V, RMAX_V));
        req_q.push_back(make_req(bsg_pkg::OpAdd, CMIN_V, CMAX_V, CMIN_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpLoad, CMIN_V, CMIN_V, CMIN_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, CMAX_V, CMAX_V, CMAX_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpLoad, CMAX_V, CMAX_V, CMAX_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, CMIN_V, CMIN_V, CMIN_V, 0));
        req_q.push_back(make_req(bsg_pkg::OpLoad, 0, 0, 0, 65536));
        req_q.push_back(make_req(bsg_pkg::OpAdd, 0, 65536, 0, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, -1, -1, -1, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, 0, 0, 3, 0));
        req_q.push_back(make_req(bsg_pkg::OpLoad, -5, 7, -9, 1));
        req_q.push_back(make_req(bsg_pkg::OpAdd, -5, 7, -8, 0));
        req_q.push_back(make_req(bsg_pkg::OpAdd, -5, 7, -7, 0));
        req_q.push_back(make_req(bsg_pkg::OpLoad, 0, 0, 0, RMAX_V));
        req_q.push_back(make_req(bsg_pkg::OpAdd, CMIN_V, CMIN_V, CMIN_V, 0));
        wait_drained();

        // Random phases with different idling.
        queue_random(300);
        wait_drained();
        send_idle_pct = 48;
        queue_random(300);
        wait_drained();
        // Hold the sender while new requests are queued, then release it.
        hold_send = 1'b1;
        queue_random(20);
        repeat (200) @(posedge i_clk);
        hold_send = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 48;
        queue_random(280);
        wait_drained();
        send_idle_pct = 16;
        recv_stall_pct = 16;
        queue_random(300);
        wait_drained();
        repeat (300) @(posedge i_clk);

        if (errors == 0) begin
            $display("** bounding_sphere_point_grow_core: PASSED **");
        end else begin
            $display("** bounding_sphere_point_grow_core: FAILED **");
        end
        $finish;
    end

endmodule
